/* design/stable_record_sorter_defines.svh */
// Assertion macros used by the stable record sorter checker.
`ifndef STABLE_RECORD_SORTER_DEFINES_SVH
`define STABLE_RECORD_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/srs_pkg.sv */
// Types and constants of the stable record sorter.
`default_nettype none

package srs_pkg;

    localparam int TAG_W  = 16;
    localparam int AGE_W  = 7;
    localparam int DIST_W = 20;
    localparam int EMIS_W = 24;
    localparam int KEY_W  = 24;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef logic [1:0] status_t;
    typedef logic [1:0] field_t;

    localparam status_t ST_LOADED   = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_EMPTY    = 2'd2;
    localparam status_t ST_UNLOADED = 2'd3;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UNLOAD = 1'b1;

    localparam field_t FIELD_AGE  = 2'd0;
    localparam field_t FIELD_DIST = 2'd1;
    localparam field_t FIELD_EMIS = 2'd2;

    localparam logic REG_SORT_FIELD = 1'b0;
    localparam logic REG_DESCENDING = 1'b1;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic load;
        logic unload;
        logic desc;
    } ctrl_t;

endpackage

`default_nettype wire

/* design/srs_in_if.sv */
// Input channel of the stable record sorter: valid/ready plus one command item.
`default_nettype none

interface srs_in_if;

    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [srs_pkg::TAG_W-1:0]   record_tag;
    logic [srs_pkg::AGE_W-1:0]   age;
    logic [srs_pkg::DIST_W-1:0]  daily_distance;
    logic [srs_pkg::EMIS_W-1:0]  monthly_emission;

    modport source (
        output valid, command, record_tag, age, daily_distance, monthly_emission,
        input  ready
    );

    modport sink (
        input  valid, command, record_tag, age, daily_distance, monthly_emission,
        output ready
    );

endinterface

`default_nettype wire

/* design/srs_out_if.sv */
// Output channel of the stable record sorter: valid/ready plus one result item.
`default_nettype none

interface srs_out_if;

    logic                        valid;
    logic                        ready;
    srs_pkg::status_t            status;
    logic [srs_pkg::TAG_W-1:0]   record_tag_res;
    logic [srs_pkg::KEY_W-1:0]   sort_key;
    logic                        last_record;

    modport source (
        output valid, status, record_tag_res, sort_key, last_record,
        input  ready
    );

    modport sink (
        input  valid, status, record_tag_res, sort_key, last_record,
        output ready
    );

endinterface

`default_nettype wire

/* design/srs_cell.sv */
// One slot of the insertion chain: holds a record, shifts right on insert, left on pop.
`default_nettype none

module srs_cell #(
    parameter int KEY_BITS = 24
) (
    input  wire logic                       clk,
    input  wire srs_pkg::ctrl_t             ctrl,
    input  wire logic                       occupied,
    input  wire logic [srs_pkg::TAG_W-1:0]  new_tag,
    input  wire logic [KEY_BITS-1:0]        new_key,
    input  wire logic [srs_pkg::TAG_W-1:0]  left_tag,
    input  wire logic [KEY_BITS-1:0]        left_key,
    input  wire logic [srs_pkg::TAG_W-1:0]  right_tag,
    input  wire logic [KEY_BITS-1:0]        right_key,
    input  wire logic                       found_in,
    output logic                            found_out,
    output logic [srs_pkg::TAG_W-1:0]       tag,
    output logic [KEY_BITS-1:0]             key
);

    import srs_pkg::*;

    logic [TAG_W-1:0]    tag_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                precedes;
    logic                place;

    assign precedes  = ctrl.desc ? (new_key > key_reg) : (new_key < key_reg);
    // New record lands at the first slot that is empty or that it strictly precedes.
    assign place     = !occupied || precedes;
    assign found_out = found_in || place;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && found_out)
        begin
            if (found_in)
            begin
                tag_reg <= left_tag;
                key_reg <= left_key;
            end
            else
            begin
                tag_reg <= new_tag;
                key_reg <= new_key;
            end
        end
        else if (ctrl.unload)
        begin
            tag_reg <= right_tag;
            key_reg <= right_key;
        end
    end

    assign tag = tag_reg;
    assign key = key_reg;

endmodule

`default_nettype wire

/* design/stable_record_sorter.sv */
// Stable record sorter: insertion chain of cells, one record per cell, head at cell 0.
// A result is registered when its item is accepted and is valid in the next cycle.
// Throughput: one item per cycle unless stalled; whole chain updates on acceptance.
// Input ready drops only while a finished result waits at the output.
// Reset clears record count, output valid and config (sort_field 2, ascending).
// Record slots are not cleared; only slots below the count reach the output.
`default_nettype none

module stable_record_sorter #(
    parameter int MAX_RECORDS = 64,
    parameter int KEY_BITS    = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    srs_in_if.sink                            rec_in,
    srs_out_if.source                         rec_out,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [srs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [srs_pkg::DATA_W-1:0]   pwdata,
    output logic      [srs_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    import srs_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    // Configuration
    field_t sort_field_reg;
    logic   descending_reg;
    logic   cfg_wr;
    logic   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_field_reg <= FIELD_EMIS;
            descending_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == REG_SORT_FIELD)
                sort_field_reg <= pwdata[1:0];
            else
                descending_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        if (cfg_idx == REG_DESCENDING)
            prdata = {{(DATA_W-1){1'b0}}, descending_reg};
        else
            prdata = {{(DATA_W-2){1'b0}}, sort_field_reg};
    end

    // Handshake and control
    logic             accept;
    logic             out_valid_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;
    ctrl_t            ctrl;

    assign rec_in.ready = !out_valid_reg || rec_out.ready;
    assign accept       = rec_in.valid && rec_in.ready;
    assign full         = (count_reg == CNT_W'(MAX_RECORDS));
    assign empty        = (count_reg == '0);

    assign ctrl.load   = accept && (rec_in.command == CMD_LOAD) && !full;
    assign ctrl.unload = accept && (rec_in.command == CMD_UNLOAD) && !empty;
    assign ctrl.desc   = descending_reg;

    always_comb
    begin
        priority if (ctrl.load)
            count_next = count_reg + 1'b1;
        else if (ctrl.unload)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Key selection with saturation to the stored key width
    logic [KEY_W-1:0]    pick_key;
    logic [KEY_BITS-1:0] new_key;
    logic [KEY_W-1:0]    head_key_out;

    always_comb
    begin
        unique case (sort_field_reg)
            FIELD_AGE:  pick_key = KEY_W'(rec_in.age);
            FIELD_DIST: pick_key = KEY_W'(rec_in.daily_distance);
            default:    pick_key = KEY_W'(rec_in.monthly_emission);
        endcase
    end

    // Chain of cells
    logic [TAG_W-1:0]    cell_tag [MAX_RECORDS];
    logic [KEY_BITS-1:0] cell_key [MAX_RECORDS];
    logic                found    [MAX_RECORDS+1];

    assign found[0] = 1'b0;

    generate
        if (KEY_BITS >= KEY_W)
        begin : g_wide_key
            assign new_key      = KEY_BITS'(pick_key);
            assign head_key_out = cell_key[0][KEY_W-1:0];
        end
        else
        begin : g_narrow_key
            assign new_key      = (|pick_key[KEY_W-1:KEY_BITS]) ? '1 : pick_key[KEY_BITS-1:0];
            assign head_key_out = KEY_W'(cell_key[0]);
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++)
        begin : g_cell
            logic [TAG_W-1:0]    l_tag;
            logic [KEY_BITS-1:0] l_key;
            logic [TAG_W-1:0]    r_tag;
            logic [KEY_BITS-1:0] r_key;

            if (gi == 0)
            begin : g_head
                assign l_tag = rec_in.record_tag;
                assign l_key = new_key;
            end
            else
            begin : g_body
                assign l_tag = cell_tag[gi-1];
                assign l_key = cell_key[gi-1];
            end

            if (gi == MAX_RECORDS - 1)
            begin : g_tail
                assign r_tag = cell_tag[gi];
                assign r_key = cell_key[gi];
            end
            else
            begin : g_inner
                assign r_tag = cell_tag[gi+1];
                assign r_key = cell_key[gi+1];
            end

            srs_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (count_reg > CNT_W'(gi)),
                .new_tag   (rec_in.record_tag),
                .new_key   (new_key),
                .left_tag  (l_tag),
                .left_key  (l_key),
                .right_tag (r_tag),
                .right_key (r_key),
                .found_in  (found[gi]),
                .found_out (found[gi+1]),
                .tag       (cell_tag[gi]),
                .key       (cell_key[gi])
            );
        end
    endgenerate

    // Result register
    status_t          status_next;
    logic [TAG_W-1:0] tag_next;
    logic [KEY_W-1:0] key_next;
    logic             last_next;
    status_t          status_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [KEY_W-1:0] key_reg;
    logic             last_reg;

    always_comb
    begin
        tag_next  = '0;
        key_next  = '0;
        last_next = 1'b0;
        priority if (rec_in.command == CMD_LOAD)
            status_next = full ? ST_FULL : ST_LOADED;
        else if (empty)
            status_next = ST_EMPTY;
        else
        begin
            status_next = ST_UNLOADED;
            tag_next    = cell_tag[0];
            key_next    = head_key_out;
            last_next   = (count_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (rec_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            tag_reg    <= tag_next;
            key_reg    <= key_next;
            last_reg   <= last_next;
        end
    end

    assign rec_out.valid          = out_valid_reg;
    assign rec_out.status         = status_reg;
    assign rec_out.record_tag_res = tag_reg;
    assign rec_out.sort_key       = key_reg;
    assign rec_out.last_record    = last_reg;

endmodule

`default_nettype wire

/* design/srs_checker.sv */
// Port-level checker for the stable record sorter, bound to the top level.
`default_nettype none
`include "stable_record_sorter_defines.svh"

module srs_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire srs_pkg::status_t            status,
    input wire logic [srs_pkg::TAG_W-1:0]   record_tag_res,
    input wire logic [srs_pkg::KEY_W-1:0]   sort_key,
    input wire logic                        last_record
);

    import srs_pkg::*;

    // Every accepted transaction yields a result in the next cycle.
    `SRS_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "result missing after transaction")

    // Input stalls only behind a blocked result.
    `SRS_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without cause")

    // Only an unloaded record carries tag, key and last flag.
    `SRS_ASSERT_NOW(a_zero_fields, out_valid && (status != ST_UNLOADED), (record_tag_res == '0) && (sort_key == '0) && !last_record, "nonzero fields on non-unload result")

    // Hold a blocked result.
    `SRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(record_tag_res) && $stable(sort_key) && $stable(last_record), "blocked result changed")

endmodule

bind stable_record_sorter srs_checker u_srs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (rec_in.valid),
    .in_ready       (rec_in.ready),
    .out_valid      (rec_out.valid),
    .out_ready      (rec_out.ready),
    .status         (rec_out.status),
    .record_tag_res (rec_out.record_tag_res),
    .sort_key       (rec_out.sort_key),
    .last_record    (rec_out.last_record)
);

`default_nettype wire

/* test/tb_stable_record_sorter.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the stable record sorter: queue-fed driver, monitor, shadow store.
module tb_stable_record_sorter;

    import srs_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int ITEM_TARGET = 1150;
    localparam logic [ADDR_W-1:0] ADDR_SORT_FIELD = ADDR_W'(4 * REG_SORT_FIELD);
    localparam logic [ADDR_W-1:0] ADDR_DESCENDING = ADDR_W'(4 * REG_DESCENDING);

    typedef struct {
        logic               command;
        logic [TAG_W-1:0]   tag;
        logic [AGE_W-1:0]   age;
        logic [DIST_W-1:0]  distance;
        logic [EMIS_W-1:0]  emis;
        bit                 drain_first;
    } sort_cmd_t;

    typedef struct {
        status_t            status;
        logic [TAG_W-1:0]   tag;
        logic [KEY_W-1:0]   key;
        logic               last;
    } sort_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    srs_in_if  in_ch ();
    srs_out_if out_ch ();

    stable_record_sorter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec_in  (in_ch),
        .rec_out (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Shadow of the sorted store and of the configuration.
    logic [TAG_W-1:0] shadow_tag [STORE_DEPTH];
    logic [KEY_W-1:0] shadow_key [STORE_DEPTH];
    int               shadow_count = 0;
    field_t           cfg_field = FIELD_EMIS;
    logic             cfg_desc = 1'b0;

    sort_cmd_t    queued_commands [$];
    sort_result_t awaited_results [$];
    int           fault_count = 0;
    bit           cmd_taken = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_run = 0;
    bit stall_high = 1'b1;
    int stall_tick = 0;

    function automatic sort_result_t sort_step(input sort_cmd_t c);
        sort_result_t r;
        logic [KEY_W-1:0] nk;
        int pos;
        int i;
        r = '{ST_EMPTY, '0, '0, 1'b0};
        if (c.command == CMD_LOAD) begin
            if (shadow_count >= STORE_DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                case (cfg_field)
                    FIELD_AGE:  nk = KEY_W'(c.age);
                    FIELD_DIST: nk = KEY_W'(c.distance);
                    default:    nk = KEY_W'(c.emis);
                endcase
                // Insert behind every record the new key does not strictly precede.
                pos = shadow_count;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (cfg_desc ? (nk > shadow_key[i]) : (nk < shadow_key[i]))
                    begin
                        pos = i;
                        break;
                    end
                end
                for (i = shadow_count; i > pos; i--)
                begin
                    shadow_tag[i] = shadow_tag[i - 1];
                    shadow_key[i] = shadow_key[i - 1];
                end
                shadow_tag[pos] = c.tag;
                shadow_key[pos] = nk;
                shadow_count++;
                r.status = ST_LOADED;
            end
        end
        else if (shadow_count != 0) begin
            r.tag = shadow_tag[0];
            r.key = shadow_key[0];
            for (i = 1; i < shadow_count; i++)
            begin
                shadow_tag[i - 1] = shadow_tag[i];
                shadow_key[i - 1] = shadow_key[i];
            end
            shadow_count--;
            r.last = (shadow_count == 0);
            r.status = ST_UNLOADED;
        end
        return r;
    endfunction

    // Monitor: check results first, then predict the transaction taken at this edge.
    always @(posedge clk)
    begin
        sort_cmd_t    seen;
        sort_result_t want;
        cmd_taken = rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $error("result transaction with nothing expected");
                fault_count++;
            end
            else begin
                want = awaited_results.pop_front();
                if (out_ch.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, out_ch.status);
                    fault_count++;
                end
                if (out_ch.record_tag_res !== want.tag) begin
                    $error("record_tag_res expected %0h actual %0h",
                           want.tag, out_ch.record_tag_res);
                    fault_count++;
                end
                if (out_ch.sort_key !== want.key) begin
                    $error("sort_key expected %0h actual %0h", want.key, out_ch.sort_key);
                    fault_count++;
                end
                if (out_ch.last_record !== want.last) begin
                    $error("last_record expected %0d actual %0d",
                           want.last, out_ch.last_record);
                    fault_count++;
                end
            end
        end
        if (cmd_taken) begin
            seen.command = in_ch.command;
            seen.tag = in_ch.record_tag;
            seen.age = in_ch.age;
            seen.distance = in_ch.daily_distance;
            seen.emis = in_ch.monthly_emission;
            seen.drain_first = 1'b0;
            awaited_results.push_back(sort_step(seen));
        end
    end

    // Driver: bursts of transactions separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (cmd_taken && queued_commands.size() != 0)
                void'(queued_commands.pop_front());
            if (cmd_taken || !in_ch.valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (queued_commands.size() == 0 ||
                         (queued_commands[0].drain_first && awaited_results.size() != 0)) begin
                    in_ch.valid <= 1'b0;
                end
                else begin
                    in_ch.valid <= 1'b1;
                    in_ch.command <= queued_commands[0].command;
                    in_ch.record_tag <= queued_commands[0].tag;
                    in_ch.age <= queued_commands[0].age;
                    in_ch.daily_distance <= queued_commands[0].distance;
                    in_ch.monthly_emission <= queued_commands[0].emis;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: stall pattern switches between free flow, coin flips, periodic and runs.
    always @(negedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end
        else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 1);
            2: out_ch.ready <= ((stall_tick % 4) != 3);
            default:
            begin
                if (stall_run == 0) begin
                    stall_high = !stall_high;
                    stall_run = $urandom_range(1, 12);
                end
                else begin
                    stall_run--;
                end
                out_ch.ready <= stall_high;
            end
        endcase
    end

    task automatic push_cmd(input logic command, input logic [TAG_W-1:0] tag,
                            input logic [AGE_W-1:0] age, input logic [DIST_W-1:0] distance,
                            input logic [EMIS_W-1:0] emis);
        queued_commands.push_back('{command, tag, age, distance, emis, 1'b0});
    endtask

    task automatic push_random(input logic command);
        sort_cmd_t c;
        c.command = command;
        c.tag = TAG_W'($urandom);
        case ($urandom_range(0, 3))
            0:
            begin
                // Tiny key range: force many ties.
                c.age = AGE_W'($urandom_range(0, 3));
                c.distance = DIST_W'($urandom_range(0, 3));
                c.emis = EMIS_W'($urandom_range(0, 3));
            end
            1:
            begin
                c.age = ($urandom_range(0, 1) == 1) ? '1 : '0;
                c.distance = ($urandom_range(0, 1) == 1) ? '1 : '0;
                c.emis = ($urandom_range(0, 1) == 1) ? '1 : '0;
            end
            default:
            begin
                c.age = AGE_W'($urandom);
                c.distance = DIST_W'($urandom);
                c.emis = EMIS_W'($urandom);
            end
        endcase
        c.drain_first = ($urandom_range(0, 39) == 0);
        queued_commands.push_back(c);
    endtask

    // Block until nothing is queued or outstanding, then let the pipeline empty.
    task automatic settle();
        while (queued_commands.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== value) begin
            $error("register readback expected %0h actual %0h", value, readback);
            fault_count++;
        end
    endtask

    task automatic configure(input field_t field, input logic desc);
        write_reg(ADDR_SORT_FIELD, DATA_W'(field));
        cfg_field = field;
        write_reg(ADDR_DESCENDING, DATA_W'(desc));
        cfg_desc = desc;
    endtask

    initial
    begin
        int issued;
        int phase;
        int level;
        int n;
        int i;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_LOAD;
        in_ch.record_tag = '0;
        in_ch.age = '0;
        in_ch.daily_distance = '0;
        in_ch.monthly_emission = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: emission key, ascending.
        push_cmd(CMD_UNLOAD, '1, '1, '1, '1);
        push_cmd(CMD_LOAD, 16'h0000, '0, '0, '0);
        push_cmd(CMD_LOAD, 16'hFFFF, '1, '1, '1);
        push_cmd(CMD_LOAD, 16'h0001, 7'd5, 20'd9, 24'h000100);
        push_cmd(CMD_LOAD, 16'h0002, 7'd6, 20'd3, 24'h000100);
        push_cmd(CMD_LOAD, 16'h0003, 7'd1, 20'd1, 24'h800000);
        for (i = 0; i < 6; i++)
            push_cmd(CMD_UNLOAD, '0, '0, '0, '0);
        settle();
        configure(FIELD_AGE, 1'b1);
        push_cmd(CMD_LOAD, 16'h0010, 7'd127, 20'd1, 24'd1);
        push_cmd(CMD_LOAD, 16'h0011, 7'd0, 20'd2, 24'd2);
        push_cmd(CMD_LOAD, 16'h0012, 7'd127, 20'd3, 24'd3);
        push_cmd(CMD_LOAD, 16'h0013, 7'd64, 20'd4, 24'd4);
        for (i = 0; i < 5; i++)
            push_cmd(CMD_UNLOAD, '0, '0, '0, '0);
        issued = 21;

        phase = 0;
        while (issued < ITEM_TARGET) begin
            settle();
            // First random phase runs the unused selector value.
            if (phase == 0)
                configure(field_t'(2'd3), 1'b0);
            else if ($urandom_range(0, 2) != 0)
                configure(field_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            level = shadow_count;
            case ((phase == 0) ? 0 : $urandom_range(0, 7))
                0:
                begin
                    // Overfill the store, then drain past empty.
                    n = STORE_DEPTH - level + $urandom_range(1, 3);
                    for (i = 0; i < n; i++)
                        push_random(CMD_LOAD);
                    issued += n;
                    n = STORE_DEPTH + $urandom_range(1, 2);
                    for (i = 0; i < n; i++)
                        push_random(CMD_UNLOAD);
                    issued += n;
                end
                1, 2, 3:
                begin
                    n = $urandom_range(1, 24);
                    for (i = 0; i < n; i++)
                        push_random(CMD_LOAD);
                    issued += n;
                    n = level + n + $urandom_range(0, 2);
                    for (i = 0; i < n; i++)
                        push_random(CMD_UNLOAD);
                    issued += n;
                end
                4, 5:
                begin
                    // Leave records stored across the next configuration change.
                    n = $urandom_range(1, 16);
                    for (i = 0; i < n; i++)
                        push_random(CMD_LOAD);
                    issued += n;
                end
                default:
                begin
                    n = $urandom_range(10, 50);
                    for (i = 0; i < n; i++)
                        push_random(($urandom_range(0, 4) < 3) ? CMD_LOAD : CMD_UNLOAD);
                    issued += n;
                end
            endcase
            phase++;
        end

        while (queued_commands.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fault_count == 0)
            $display("stable_record_sorter verification clean");
        else
            $display("stable_record_sorter verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("stable_record_sorter verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/srs_pkg.sv
design/srs_in_if.sv
design/srs_out_if.sv
design/srs_cell.sv
design/stable_record_sorter.sv
design/srs_checker.sv
test/tb_stable_record_sorter.sv
